[rtl/vna_pkg.sv]
package vna_pkg;

  // Store geometry
  localparam int MAX_VERTICES = 1024;
  localparam int ADDR_W       = $clog2(MAX_VERTICES);
  localparam int VCNT_W       = 11;

  // Field widths
  localparam int FUNC_W = 2;
  localparam int POS_W  = 32;
  localparam int SUM_W  = 24;
  localparam int NORM_W = 16;

  // Arithmetic widths
  localparam int EDGE_W    = POS_W + 1;
  localparam int MAG_W     = 62;
  localparam int FIT_W     = 30;
  localparam int PROD_W    = 2 * FIT_W;
  localparam int ACC_W     = 63;
  localparam int ROOT_W    = 63;
  localparam int LEN_W     = 32;
  localparam int QUO_W     = 16;
  localparam int ONE_SHIFT = 14;
  localparam int NUM_W     = FIT_W + ONE_SHIFT + 1;
  localparam int NUM_VEC   = 6;
  localparam int VEC_IDX_W = 3;

  // Sequencer step counts
  localparam int CNT_W      = 5;
  localparam int ROOT_STEPS = ROOT_W / 2 + 1;
  localparam int DIV_STEPS  = QUO_W;
  localparam int CROSS_MULS = 6;
  localparam int SQ_MULS    = 3;
  localparam int POS_READS  = 3;

  // Configuration port
  localparam int PADDR_W  = 3;
  localparam int PDATA_W  = 32;
  localparam logic [0:0] REG_VERTEX_COUNT = 1'b0;

  // Corner / slot selection for store addresses
  localparam logic [1:0] SEL_A    = 2'd0;
  localparam logic [1:0] SEL_B    = 2'd1;
  localparam logic [1:0] SEL_C    = 2'd2;
  localparam logic [1:0] SEL_SLOT = 2'd3;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_LOAD     = 2'd0,
    FUNC_TRIANGLE = 2'd1,
    FUNC_QUERY    = 2'd2,
    FUNC_NONE     = 2'd3
  } func_e;

  typedef struct packed {
    logic [FUNC_W-1:0]       func;
    logic [ADDR_W-1:0]       vertex_slot;
    logic signed [POS_W-1:0] pos_x;
    logic signed [POS_W-1:0] pos_y;
    logic signed [POS_W-1:0] pos_z;
    logic [ADDR_W-1:0]       corner_a;
    logic [ADDR_W-1:0]       corner_b;
    logic [ADDR_W-1:0]       corner_c;
  } item_t;

  typedef struct packed {
    logic                 cap_item;
    logic                 clr_wr;
    logic                 pos_wr;
    logic                 pos_rd;
    logic [1:0]           pos_rd_sel;
    logic                 pos_cap;
    logic [1:0]           pos_cap_idx;
    logic                 sum_rd;
    logic                 sum_zero;
    logic                 sum_add;
    logic [1:0]           sum_sel;
    logic                 edge_load;
    logic                 shrink_step;
    logic                 mul_en;
    logic [VEC_IDX_W-1:0] mul_a;
    logic [VEC_IDX_W-1:0] mul_b;
    logic [1:0]           acc_idx;
    logic                 acc_sub;
    logic                 mag_from_acc;
    logic                 mag_from_sum;
    logic                 root_init;
    logic                 root_step;
    logic                 div_init;
    logic                 div_step;
    logic                 div_store;
    logic [1:0]           div_idx;
    logic                 out_load;
    logic                 out_bad;
  } cmd_t;

  typedef struct packed {
    logic              fit;
    logic              tri_ok;
    logic              slot_ok;
    logic              clr_done;
    logic              out_free;
    logic [FUNC_W-1:0] func;
  } stat_t;

endpackage

[rtl/vna_if.sv]
interface vna_in_if;
  logic                                 valid;
  logic                                 ready;
  logic [vna_pkg::FUNC_W-1:0]           func;
  logic [vna_pkg::ADDR_W-1:0]           vertex_slot;
  logic signed [vna_pkg::POS_W-1:0]     pos_x;
  logic signed [vna_pkg::POS_W-1:0]     pos_y;
  logic signed [vna_pkg::POS_W-1:0]     pos_z;
  logic [vna_pkg::ADDR_W-1:0]           corner_a;
  logic [vna_pkg::ADDR_W-1:0]           corner_b;
  logic [vna_pkg::ADDR_W-1:0]           corner_c;

  modport source (output valid, func, vertex_slot, pos_x, pos_y, pos_z,
                  corner_a, corner_b, corner_c, input ready);
  modport sink   (input valid, func, vertex_slot, pos_x, pos_y, pos_z,
                  corner_a, corner_b, corner_c, output ready);
endinterface

interface vna_out_if;
  logic                              valid;
  logic                              ready;
  logic signed [vna_pkg::NORM_W-1:0] normal_x;
  logic signed [vna_pkg::NORM_W-1:0] normal_y;
  logic signed [vna_pkg::NORM_W-1:0] normal_z;
  logic                              bad_index;

  modport source (output valid, normal_x, normal_y, normal_z, bad_index, input ready);
  modport sink   (input valid, normal_x, normal_y, normal_z, bad_index, output ready);
endinterface

[rtl/vna_dp.sv]
module vna_dp (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  vna_pkg::cmd_t                cmd_i,
  output vna_pkg::stat_t               stat_o,
  input  vna_pkg::item_t               item_i,
  input  logic [vna_pkg::VCNT_W-1:0]   vcount_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic signed [vna_pkg::NORM_W-1:0] out_x_o,
  output logic signed [vna_pkg::NORM_W-1:0] out_y_o,
  output logic signed [vna_pkg::NORM_W-1:0] out_z_o,
  output logic                         out_bad_o
);

  localparam int PW = vna_pkg::POS_W;
  localparam int SW = vna_pkg::SUM_W;
  localparam int NW = vna_pkg::NORM_W;
  localparam logic signed [SW:0] SUM_HI = (SW+1)'((64'sd1 <<< (SW - 1)) - 1);
  localparam logic signed [SW:0] SUM_LO = -SUM_HI - 1;

  vna_pkg::item_t item_q;

  logic [3*PW-1:0] pos_mem [vna_pkg::MAX_VERTICES];
  logic [3*SW-1:0] sum_mem [vna_pkg::MAX_VERTICES];
  logic [3*PW-1:0] pos_rd_q;
  logic [3*SW-1:0] sum_rd_q;
  logic [2:0][3*PW-1:0] corner_pos_q;

  logic [vna_pkg::ADDR_W-1:0] clr_cnt_q;

  logic [vna_pkg::NUM_VEC-1:0][vna_pkg::MAG_W-1:0] mag_q;
  logic [vna_pkg::NUM_VEC-1:0]                     sgn_q;

  logic [vna_pkg::PROD_W-1:0] prod_q;
  logic                       pend_q;
  logic                       neg_q;
  logic [1:0]                 acc_idx_q;
  logic [2:0][vna_pkg::ACC_W-1:0] acc_q;

  logic [vna_pkg::ROOT_W-1:0] rx_q, rres_q, rbit_q;
  logic [vna_pkg::LEN_W-1:0]  rem_q;
  logic [vna_pkg::QUO_W-1:0]  nbits_q, quo_q;
  logic [2:0][NW-1:0]         res_q;

  logic                 out_valid_q;
  logic [NW-1:0]        out_x_q, out_y_q, out_z_q;
  logic                 out_bad_q;

  logic [vna_pkg::ADDR_W-1:0] pos_raddr, sum_addr;
  logic [3*SW-1:0]            sum_new;
  logic [vna_pkg::LEN_W-1:0]  len;

  // Map a corner / slot select to a store address
  function automatic logic [vna_pkg::ADDR_W-1:0] sel_addr(vna_pkg::item_t it,
                                                         logic [1:0] sel);
    logic [vna_pkg::ADDR_W-1:0] a;
    case (sel)
      vna_pkg::SEL_A: a = it.corner_a;
      vna_pkg::SEL_B: a = it.corner_b;
      vna_pkg::SEL_C: a = it.corner_c;
      default:        a = it.vertex_slot;
    endcase
    return a;
  endfunction

  assign pos_raddr = sel_addr(item_q, cmd_i.pos_rd_sel);
  assign sum_addr  = sel_addr(item_q, cmd_i.sum_sel);
  assign len       = rres_q[vna_pkg::LEN_W-1:0];

  // Saturating add of the face normal into the read-back sums
  always_comb begin
    logic signed [SW:0] s;
    for (int k = 0; k < 3; k++) begin
      s = (SW+1)'($signed(sum_rd_q[(2-k)*SW +: SW])) + (SW+1)'($signed(res_q[k]));
      if (s > SUM_HI) begin
        s = SUM_HI;
      end else if (s < SUM_LO) begin
        s = SUM_LO;
      end
      sum_new[(2-k)*SW +: SW] = s[SW-1:0];
    end
  end

  // Position store
  always_ff @(posedge clk_i) begin
    if (cmd_i.pos_wr) begin
      pos_mem[item_q.vertex_slot] <= {item_q.pos_x, item_q.pos_y, item_q.pos_z};
    end
    if (cmd_i.pos_rd) begin
      pos_rd_q <= pos_mem[pos_raddr];
    end
  end

  // Normal sum store: clear sweep, load clear, accumulate
  always_ff @(posedge clk_i) begin
    if (cmd_i.clr_wr) begin
      sum_mem[clr_cnt_q] <= '0;
    end else if (cmd_i.sum_zero) begin
      sum_mem[sum_addr] <= '0;
    end else if (cmd_i.sum_add) begin
      sum_mem[sum_addr] <= sum_new;
    end
    if (cmd_i.sum_rd) begin
      sum_rd_q <= sum_mem[sum_addr];
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.cap_item) begin
      item_q <= item_i;
    end
    if (cmd_i.pos_cap) begin
      corner_pos_q[cmd_i.pos_cap_idx] <= pos_rd_q;
    end

    // Magnitude / sign vector
    if (cmd_i.edge_load) begin
      for (int k = 0; k < 3; k++) begin
        logic signed [vna_pkg::EDGE_W-1:0] e1, e2;
        e1 = vna_pkg::EDGE_W'($signed(corner_pos_q[1][(2-k)*PW +: PW]))
           - vna_pkg::EDGE_W'($signed(corner_pos_q[0][(2-k)*PW +: PW]));
        e2 = vna_pkg::EDGE_W'($signed(corner_pos_q[2][(2-k)*PW +: PW]))
           - vna_pkg::EDGE_W'($signed(corner_pos_q[0][(2-k)*PW +: PW]));
        sgn_q[k]   <= e1[vna_pkg::EDGE_W-1];
        sgn_q[k+3] <= e2[vna_pkg::EDGE_W-1];
        mag_q[k]   <= vna_pkg::MAG_W'(e1[vna_pkg::EDGE_W-1] ? -e1 : e1);
        mag_q[k+3] <= vna_pkg::MAG_W'(e2[vna_pkg::EDGE_W-1] ? -e2 : e2);
      end
    end else if (cmd_i.shrink_step) begin
      for (int k = 0; k < vna_pkg::NUM_VEC; k++) begin
        mag_q[k] <= mag_q[k] >> 1;
      end
    end else if (cmd_i.mag_from_acc) begin
      for (int k = 0; k < 3; k++) begin
        logic [vna_pkg::ACC_W-1:0] a;
        a = acc_q[k][vna_pkg::ACC_W-1] ? -acc_q[k] : acc_q[k];
        sgn_q[k]   <= acc_q[k][vna_pkg::ACC_W-1];
        mag_q[k]   <= a[vna_pkg::MAG_W-1:0];
        sgn_q[k+3] <= 1'b0;
        mag_q[k+3] <= '0;
      end
    end else if (cmd_i.mag_from_sum) begin
      for (int k = 0; k < 3; k++) begin
        logic signed [SW:0] v;
        v = (SW+1)'($signed(sum_rd_q[(2-k)*SW +: SW]));
        sgn_q[k]   <= v[SW];
        mag_q[k]   <= vna_pkg::MAG_W'(v[SW] ? -v : v);
        sgn_q[k+3] <= 1'b0;
        mag_q[k+3] <= '0;
      end
    end

    // Shared multiplier; the product is registered and accumulated in the next cycle
    if (cmd_i.mul_en) begin
      prod_q    <= mag_q[cmd_i.mul_a][vna_pkg::FIT_W-1:0]
                 * mag_q[cmd_i.mul_b][vna_pkg::FIT_W-1:0];
      neg_q     <= sgn_q[cmd_i.mul_a] ^ sgn_q[cmd_i.mul_b] ^ cmd_i.acc_sub;
      acc_idx_q <= cmd_i.acc_idx;
    end
    if (cmd_i.edge_load || cmd_i.mag_from_acc || cmd_i.mag_from_sum) begin
      acc_q <= '0;
    end else if (pend_q) begin
      acc_q[acc_idx_q] <= neg_q ? acc_q[acc_idx_q] - vna_pkg::ACC_W'(prod_q)
                                : acc_q[acc_idx_q] + vna_pkg::ACC_W'(prod_q);
    end

    // Integer square root, two radicand bits per step
    if (cmd_i.root_init) begin
      rx_q   <= acc_q[0];
      rres_q <= '0;
      rbit_q <= vna_pkg::ROOT_W'(1) << (vna_pkg::ROOT_W - 1);
    end else if (cmd_i.root_step) begin
      logic [vna_pkg::ROOT_W:0] trial;
      trial = (vna_pkg::ROOT_W+1)'(rres_q) + (vna_pkg::ROOT_W+1)'(rbit_q);
      if ((vna_pkg::ROOT_W+1)'(rx_q) >= trial) begin
        rx_q   <= rx_q - trial[vna_pkg::ROOT_W-1:0];
        rres_q <= (rres_q >> 1) + rbit_q;
      end else begin
        rres_q <= rres_q >> 1;
      end
      rbit_q <= rbit_q >> 2;
    end

    // Restoring division, one quotient bit per step
    if (cmd_i.div_init) begin
      logic [vna_pkg::NUM_W-1:0] num;
      num = {1'b0, mag_q[{1'b0, cmd_i.div_idx}][vna_pkg::FIT_W-1:0],
             vna_pkg::ONE_SHIFT'(0)} + vna_pkg::NUM_W'(len >> 1);
      rem_q   <= vna_pkg::LEN_W'(num[vna_pkg::NUM_W-1:vna_pkg::QUO_W]);
      nbits_q <= num[vna_pkg::QUO_W-1:0];
      quo_q   <= '0;
    end else if (cmd_i.div_step) begin
      logic [vna_pkg::LEN_W:0] r2;
      r2 = {rem_q, nbits_q[vna_pkg::QUO_W-1]};
      if (r2 >= {1'b0, len}) begin
        rem_q <= vna_pkg::LEN_W'(r2 - {1'b0, len});
        quo_q <= {quo_q[vna_pkg::QUO_W-2:0], 1'b1};
      end else begin
        rem_q <= r2[vna_pkg::LEN_W-1:0];
        quo_q <= {quo_q[vna_pkg::QUO_W-2:0], 1'b0};
      end
      nbits_q <= nbits_q << 1;
    end
    if (cmd_i.div_store) begin
      if (len == '0) begin
        res_q[cmd_i.div_idx] <= '0;
      end else begin
        res_q[cmd_i.div_idx] <= sgn_q[{1'b0, cmd_i.div_idx}] ? NW'(-quo_q) : NW'(quo_q);
      end
    end

    // Result register payload
    if (cmd_i.out_load) begin
      out_bad_q <= cmd_i.out_bad;
      out_x_q   <= cmd_i.out_bad ? '0 : res_q[0];
      out_y_q   <= cmd_i.out_bad ? '0 : res_q[1];
      out_z_q   <= cmd_i.out_bad ? '0 : res_q[2];
    end
  end

  // Control registers: clear sweep, pending product, result valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_cnt_q   <= '0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.clr_wr) begin
        clr_cnt_q <= clr_cnt_q + 1'b1;
      end
      pend_q <= cmd_i.mul_en;
      if (cmd_i.out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Status toward the controller
  always_comb begin
    stat_o.fit = 1'b1;
    for (int k = 0; k < vna_pkg::NUM_VEC; k++) begin
      if (mag_q[k][vna_pkg::MAG_W-1:vna_pkg::FIT_W] != '0) begin
        stat_o.fit = 1'b0;
      end
    end
    stat_o.tri_ok   = (vna_pkg::VCNT_W'(item_q.corner_a) < vcount_i)
                   && (vna_pkg::VCNT_W'(item_q.corner_b) < vcount_i)
                   && (vna_pkg::VCNT_W'(item_q.corner_c) < vcount_i);
    stat_o.slot_ok  = vna_pkg::VCNT_W'(item_q.vertex_slot) < vcount_i;
    stat_o.clr_done = clr_cnt_q == vna_pkg::ADDR_W'(vna_pkg::MAX_VERTICES - 1);
    stat_o.out_free = !out_valid_q || out_ready_i;
    stat_o.func     = item_q.func;
  end

  assign out_valid_o = out_valid_q;
  assign out_x_o     = out_x_q;
  assign out_y_o     = out_y_q;
  assign out_z_o     = out_z_q;
  assign out_bad_o   = out_bad_q;

endmodule

[rtl/vna_ctrl.sv]
module vna_ctrl (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  input  logic [vna_pkg::FUNC_W-1:0] in_func_i,
  output logic                       in_ready_o,
  input  vna_pkg::stat_t             stat_i,
  output vna_pkg::cmd_t              cmd_o
);

  typedef enum logic [4:0] {
    S_CLEAR, S_IDLE, S_LOAD, S_TRI_CHK, S_POS_RD, S_EDGE, S_SHRINK, S_CROSS,
    S_LOADN, S_SQUARE, S_ROOT_INIT, S_ROOT, S_DIV_INIT, S_DIV, S_DIV_STORE,
    S_ADD_RD, S_ADD_WR, S_Q_CHK, S_Q_RD, S_Q_LOAD, S_OUT
  } state_e;

  state_e                    state_q, state_d;
  logic [vna_pkg::CNT_W-1:0] cnt_q, cnt_d;
  logic [1:0]                comp_q, comp_d;
  logic                      to_sq_q, to_sq_d;

  always_comb begin
    state_d    = state_q;
    cnt_d      = cnt_q;
    comp_d     = comp_q;
    to_sq_d    = to_sq_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;

    case (state_q)
      S_CLEAR: begin
        cmd_o.clr_wr = 1'b1;
        if (stat_i.clr_done) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.cap_item = 1'b1;
          case (vna_pkg::func_e'(in_func_i))
            vna_pkg::FUNC_LOAD:     state_d = S_LOAD;
            vna_pkg::FUNC_TRIANGLE: state_d = S_TRI_CHK;
            vna_pkg::FUNC_QUERY:    state_d = S_Q_CHK;
            default:                state_d = S_IDLE;
          endcase
        end
      end
      S_LOAD: begin
        cmd_o.pos_wr   = 1'b1;
        cmd_o.sum_zero = 1'b1;
        cmd_o.sum_sel  = vna_pkg::SEL_SLOT;
        state_d        = S_IDLE;
      end
      S_TRI_CHK: begin
        cnt_d   = '0;
        state_d = stat_i.tri_ok ? S_POS_RD : S_IDLE;
      end
      // Read corners a, b, c; capture each from the read register in the next cycle
      S_POS_RD: begin
        if (cnt_q < vna_pkg::CNT_W'(vna_pkg::POS_READS)) begin
          cmd_o.pos_rd     = 1'b1;
          cmd_o.pos_rd_sel = cnt_q[1:0];
        end
        if (cnt_q != '0) begin
          cmd_o.pos_cap     = 1'b1;
          cmd_o.pos_cap_idx = 2'(cnt_q - 1'b1);
        end
        if (cnt_q == vna_pkg::CNT_W'(vna_pkg::POS_READS)) begin
          state_d = S_EDGE;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      S_EDGE: begin
        cmd_o.edge_load = 1'b1;
        to_sq_d         = 1'b0;
        state_d         = S_SHRINK;
      end
      S_SHRINK: begin
        if (stat_i.fit) begin
          cnt_d   = '0;
          state_d = to_sq_q ? S_SQUARE : S_CROSS;
        end else begin
          cmd_o.shrink_step = 1'b1;
        end
      end
      // Six products of the cross product, then a drain step for the last product
      S_CROSS: begin
        if (cnt_q < vna_pkg::CNT_W'(vna_pkg::CROSS_MULS)) begin
          cmd_o.mul_en = 1'b1;
          case (cnt_q[2:0])
            3'd0: begin cmd_o.mul_a = 3'd1; cmd_o.mul_b = 3'd5; cmd_o.acc_idx = 2'd0; end
            3'd1: begin cmd_o.mul_a = 3'd2; cmd_o.mul_b = 3'd4; cmd_o.acc_idx = 2'd0;
                        cmd_o.acc_sub = 1'b1; end
            3'd2: begin cmd_o.mul_a = 3'd2; cmd_o.mul_b = 3'd3; cmd_o.acc_idx = 2'd1; end
            3'd3: begin cmd_o.mul_a = 3'd0; cmd_o.mul_b = 3'd5; cmd_o.acc_idx = 2'd1;
                        cmd_o.acc_sub = 1'b1; end
            3'd4: begin cmd_o.mul_a = 3'd0; cmd_o.mul_b = 3'd4; cmd_o.acc_idx = 2'd2; end
            default: begin cmd_o.mul_a = 3'd1; cmd_o.mul_b = 3'd3; cmd_o.acc_idx = 2'd2;
                        cmd_o.acc_sub = 1'b1; end
          endcase
        end
        if (cnt_q == vna_pkg::CNT_W'(vna_pkg::CROSS_MULS)) begin
          state_d = S_LOADN;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      S_LOADN: begin
        cmd_o.mag_from_acc = 1'b1;
        to_sq_d            = 1'b1;
        state_d            = S_SHRINK;
      end
      // Sum of squares into accumulator zero
      S_SQUARE: begin
        if (cnt_q < vna_pkg::CNT_W'(vna_pkg::SQ_MULS)) begin
          cmd_o.mul_en = 1'b1;
          cmd_o.mul_a  = vna_pkg::VEC_IDX_W'(cnt_q);
          cmd_o.mul_b  = vna_pkg::VEC_IDX_W'(cnt_q);
        end
        if (cnt_q == vna_pkg::CNT_W'(vna_pkg::SQ_MULS)) begin
          state_d = S_ROOT_INIT;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      S_ROOT_INIT: begin
        cmd_o.root_init = 1'b1;
        cnt_d           = '0;
        state_d         = S_ROOT;
      end
      S_ROOT: begin
        cmd_o.root_step = 1'b1;
        if (cnt_q == vna_pkg::CNT_W'(vna_pkg::ROOT_STEPS - 1)) begin
          comp_d  = '0;
          state_d = S_DIV_INIT;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      S_DIV_INIT: begin
        cmd_o.div_init = 1'b1;
        cmd_o.div_idx  = comp_q;
        cnt_d          = '0;
        state_d        = S_DIV;
      end
      S_DIV: begin
        cmd_o.div_step = 1'b1;
        if (cnt_q == vna_pkg::CNT_W'(vna_pkg::DIV_STEPS - 1)) begin
          state_d = S_DIV_STORE;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      S_DIV_STORE: begin
        cmd_o.div_store = 1'b1;
        cmd_o.div_idx   = comp_q;
        if (comp_q == 2'd2) begin
          comp_d  = '0;
          state_d = (stat_i.func == vna_pkg::FUNC_QUERY) ? S_OUT : S_ADD_RD;
        end else begin
          comp_d  = comp_q + 1'b1;
          state_d = S_DIV_INIT;
        end
      end
      // Read-modify-write of each corner's sum, a then b then c
      S_ADD_RD: begin
        cmd_o.sum_rd  = 1'b1;
        cmd_o.sum_sel = comp_q;
        state_d       = S_ADD_WR;
      end
      S_ADD_WR: begin
        cmd_o.sum_add = 1'b1;
        cmd_o.sum_sel = comp_q;
        if (comp_q == 2'd2) begin
          state_d = S_IDLE;
        end else begin
          comp_d  = comp_q + 1'b1;
          state_d = S_ADD_RD;
        end
      end
      S_Q_CHK: begin
        state_d = stat_i.slot_ok ? S_Q_RD : S_OUT;
      end
      S_Q_RD: begin
        cmd_o.sum_rd  = 1'b1;
        cmd_o.sum_sel = vna_pkg::SEL_SLOT;
        state_d       = S_Q_LOAD;
      end
      S_Q_LOAD: begin
        cmd_o.mag_from_sum = 1'b1;
        to_sq_d            = 1'b1;
        state_d            = S_SHRINK;
      end
      // Hold until the result register is free
      S_OUT: begin
        if (stat_i.out_free) begin
          cmd_o.out_load = 1'b1;
          cmd_o.out_bad  = !stat_i.slot_ok;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      cnt_q   <= '0;
      comp_q  <= '0;
      to_sq_q <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      comp_q  <= comp_d;
      to_sq_q <= to_sq_d;
    end
  end

endmodule

[rtl/vertex_normal_accumulate_unit.sv]
// Vertex normal accumulator.
// Input channel in_i carries one command per transfer: load a vertex position
// (clears its normal sum), add a triangle (unit face normal summed into its
// three corners), or query a vertex (one transfer on out_o with the unit
// normal of its sum, or zeros and bad_index for a slot at or beyond
// vertex_count). Triangles with a corner out of range are dropped.
// vertex_count is written over the APB port at byte address 0.
// After reset all 1024 entries of the normal-sum store are swept to zero
// with in_i.ready low; then one command is processed at a time.
// A triangle's time is set mostly by the 32-step square root and the three
// 16-step divisions of the normalizer, plus one right-shift step per bit
// needed to fit the edges (0 to 2) and the cross product (0 to 31) into
// 30 bits. A query result sits in an output register; the next command is
// taken while it waits, and a further query stalls only if out_o has not
// taken the previous result.
module vertex_normal_accumulate_unit (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  vna_in_if.sink                       in_i,
  vna_out_if.source                    out_o,
  input  logic                         psel_i,
  input  logic                         penable_i,
  input  logic                         pwrite_i,
  input  logic [vna_pkg::PADDR_W-1:0]  paddr_i,
  input  logic [vna_pkg::PDATA_W-1:0]  pwdata_i,
  output logic [vna_pkg::PDATA_W-1:0]  prdata_o,
  output logic                         pready_o
);

  logic [vna_pkg::VCNT_W-1:0] vcount_q;
  logic                       reg_sel;
  vna_pkg::item_t             item;
  vna_pkg::cmd_t              cmd;
  vna_pkg::stat_t             stat;

  // Register file: vertex_count only
  assign reg_sel  = paddr_i[vna_pkg::PADDR_W-1:2] == vna_pkg::REG_VERTEX_COUNT;
  assign pready_o = 1'b1;
  assign prdata_o = reg_sel ? vna_pkg::PDATA_W'(vcount_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vcount_q <= '0;
    end else if (psel_i && penable_i && pwrite_i && reg_sel) begin
      vcount_q <= pwdata_i[vna_pkg::VCNT_W-1:0];
    end
  end

  assign item.func        = in_i.func;
  assign item.vertex_slot = in_i.vertex_slot;
  assign item.pos_x       = in_i.pos_x;
  assign item.pos_y       = in_i.pos_y;
  assign item.pos_z       = in_i.pos_z;
  assign item.corner_a    = in_i.corner_a;
  assign item.corner_b    = in_i.corner_b;
  assign item.corner_c    = in_i.corner_c;

  vna_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_func_i  (in_i.func),
    .in_ready_o (in_i.ready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  vna_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .item_i      (item),
    .vcount_i    (vcount_q),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .out_x_o     (out_o.normal_x),
    .out_y_o     (out_o.normal_y),
    .out_z_o     (out_o.normal_z),
    .out_bad_o   (out_o.bad_index)
  );

endmodule

[rtl/vna_checker.sv]
module vna_checker (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              out_valid_i,
  input logic                              out_ready_i,
  input logic signed [vna_pkg::NORM_W-1:0] normal_x_i,
  input logic signed [vna_pkg::NORM_W-1:0] normal_y_i,
  input logic signed [vna_pkg::NORM_W-1:0] normal_z_i,
  input logic                              bad_index_i,
  input logic                              psel_i,
  input logic                              penable_i,
  input logic                              pwrite_i,
  input logic [vna_pkg::PADDR_W-1:0]       paddr_i,
  input logic [vna_pkg::PDATA_W-1:0]       pwdata_i,
  input logic [vna_pkg::PDATA_W-1:0]       prdata_i
);

  localparam logic signed [vna_pkg::NORM_W-1:0] ONE = vna_pkg::NORM_W'(1 << vna_pkg::ONE_SHIFT);

  // A result waiting on the receiver stays offered
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result dropped while stalled");

  // A rejected query carries a zero normal
  a_bad_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && bad_index_i |->
      normal_x_i == '0 && normal_y_i == '0 && normal_z_i == '0)
    else $error("bad query with nonzero normal");

  // Unit normal components stay within one
  a_unit_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |->
      normal_x_i <= ONE && normal_x_i >= -ONE && normal_y_i <= ONE && normal_y_i >= -ONE
      && normal_z_i <= ONE && normal_z_i >= -ONE)
    else $error("normal component out of range");

  // vertex_count reads back what was written
  a_reg_readback: assert property (@(posedge clk_i) disable iff (!rst_ni)
    psel_i && penable_i && pwrite_i && paddr_i == '0 ##1 paddr_i == '0 |->
      prdata_i == vna_pkg::PDATA_W'($past(pwdata_i[vna_pkg::VCNT_W-1:0])))
    else $error("vertex_count readback mismatch");

endmodule

bind vertex_normal_accumulate_unit vna_checker u_vna_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .normal_x_i  (out_o.normal_x),
  .normal_y_i  (out_o.normal_y),
  .normal_z_i  (out_o.normal_z),
  .bad_index_i (out_o.bad_index),
  .psel_i      (psel_i),
  .penable_i   (penable_i),
  .pwrite_i    (pwrite_i),
  .paddr_i     (paddr_i),
  .pwdata_i    (pwdata_i),
  .prdata_i    (prdata_o)
);

[tb/tb_top.sv]
`timescale 1ns / 1ps

module tb_top;

  localparam int HALF_PERIOD = 5;
  localparam int DRAIN_CYCLES = 300;
  localparam int LONG_HOLD = 800;
  localparam longint SUM_MAX = (64'sd1 <<< (vna_pkg::SUM_W - 1)) - 1;
  localparam longint SUM_MIN = -SUM_MAX - 1;
  localparam longint ONE_POS = 64'sd65536;

  typedef struct {
    logic signed [vna_pkg::NORM_W-1:0] nx;
    logic signed [vna_pkg::NORM_W-1:0] ny;
    logic signed [vna_pkg::NORM_W-1:0] nz;
    logic                              bad;
  } normal_t;

  logic clk_i;
  logic rst_ni;
  logic psel_i;
  logic penable_i;
  logic pwrite_i;
  logic [vna_pkg::PADDR_W-1:0] paddr_i;
  logic [vna_pkg::PDATA_W-1:0] pwdata_i;
  logic [vna_pkg::PDATA_W-1:0] prdata_o;
  logic pready_o;

  vna_in_if  in_bus ();
  vna_out_if out_bus ();

  vertex_normal_accumulate_unit uut (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_i      (in_bus),
    .out_o     (out_bus),
    .psel_i    (psel_i),
    .penable_i (penable_i),
    .pwrite_i  (pwrite_i),
    .paddr_i   (paddr_i),
    .pwdata_i  (pwdata_i),
    .prdata_o  (prdata_o),
    .pready_o  (pready_o)
  );

  // Mirror of the block state
  longint  coord_x [vna_pkg::MAX_VERTICES];
  longint  coord_y [vna_pkg::MAX_VERTICES];
  longint  coord_z [vna_pkg::MAX_VERTICES];
  longint  nsum_x  [vna_pkg::MAX_VERTICES];
  longint  nsum_y  [vna_pkg::MAX_VERTICES];
  longint  nsum_z  [vna_pkg::MAX_VERTICES];
  bit      placed  [vna_pkg::MAX_VERTICES];
  int      placed_list[$];
  int      active_count;

  normal_t pending_normals[$];
  int      err_count;
  int      result_count;
  int      item_count;
  bit      quiet;
  bit      hold_request;

  always #HALF_PERIOD clk_i = ~clk_i;

  // ---------------------------------------------------------------- arithmetic
  function automatic longint unsigned mag(longint v);
    return (v < 0) ? longint'(-v) : longint'(v);
  endfunction

  function automatic int fit_shift(longint unsigned m);
    int s;
    s = 0;
    while ((m >> s) >= (64'd1 << vna_pkg::FIT_W)) s++;
    return s;
  endfunction

  function automatic longint shr_keep_sign(longint v, int s);
    longint r;
    r = longint'(mag(v) >> s);
    return (v < 0) ? -r : r;
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned x);
    longint unsigned res;
    longint unsigned bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > x) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (x >= res + bitv) begin
        x = x - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  // Scale a vector to a Q1.14 unit vector; zero stays zero
  function automatic void unitize(inout longint x, inout longint y, inout longint z);
    longint unsigned m;
    longint unsigned sq;
    longint unsigned len;
    int s;
    m = mag(x);
    if (mag(y) > m) m = mag(y);
    if (mag(z) > m) m = mag(z);
    s = fit_shift(m);
    x = shr_keep_sign(x, s);
    y = shr_keep_sign(y, s);
    z = shr_keep_sign(z, s);
    sq = mag(x) * mag(x) + mag(y) * mag(y) + mag(z) * mag(z);
    len = int_sqrt(sq);
    if (len == 0) begin
      x = 0; y = 0; z = 0;
    end else begin
      x = (x < 0) ? -longint'((mag(x) * 16384 + len / 2) / len)
                  : longint'((mag(x) * 16384 + len / 2) / len);
      y = (y < 0) ? -longint'((mag(y) * 16384 + len / 2) / len)
                  : longint'((mag(y) * 16384 + len / 2) / len);
      z = (z < 0) ? -longint'((mag(z) * 16384 + len / 2) / len)
                  : longint'((mag(z) * 16384 + len / 2) / len);
    end
  endfunction

  function automatic longint sat_sum(longint a, longint b);
    longint r;
    r = a + b;
    if (r > SUM_MAX) return SUM_MAX;
    if (r < SUM_MIN) return SUM_MIN;
    return r;
  endfunction

  function automatic bit in_use(int idx);
    return idx < active_count;
  endfunction

  // Update the mirror for one accepted command; queue a normal for a query
  function automatic void apply_command(vna_pkg::item_t it);
    longint e[6];
    longint nx, ny, nz;
    longint unsigned m;
    int s, a, b, c;
    int corners[3];
    normal_t res;
    case (vna_pkg::func_e'(it.func))
      vna_pkg::FUNC_LOAD: begin
        coord_x[it.vertex_slot] = it.pos_x;
        coord_y[it.vertex_slot] = it.pos_y;
        coord_z[it.vertex_slot] = it.pos_z;
        nsum_x[it.vertex_slot] = 0;
        nsum_y[it.vertex_slot] = 0;
        nsum_z[it.vertex_slot] = 0;
        if (!placed[it.vertex_slot]) begin
          placed[it.vertex_slot] = 1;
          placed_list = {placed_list, int'(it.vertex_slot)};
        end
      end
      vna_pkg::FUNC_TRIANGLE: begin
        a = it.corner_a; b = it.corner_b; c = it.corner_c;
        if (in_use(a) && in_use(b) && in_use(c)) begin
          e[0] = coord_x[b] - coord_x[a];
          e[1] = coord_y[b] - coord_y[a];
          e[2] = coord_z[b] - coord_z[a];
          e[3] = coord_x[c] - coord_x[a];
          e[4] = coord_y[c] - coord_y[a];
          e[5] = coord_z[c] - coord_z[a];
          m = 0;
          for (int i = 0; i < 6; i++) if (mag(e[i]) > m) m = mag(e[i]);
          s = fit_shift(m);
          for (int i = 0; i < 6; i++) e[i] = shr_keep_sign(e[i], s);
          nx = e[1] * e[5] - e[2] * e[4];
          ny = e[2] * e[3] - e[0] * e[5];
          nz = e[0] * e[4] - e[1] * e[3];
          unitize(nx, ny, nz);
          corners[0] = a; corners[1] = b; corners[2] = c;
          for (int j = 0; j < 3; j++) begin
            nsum_x[corners[j]] = sat_sum(nsum_x[corners[j]], nx);
            nsum_y[corners[j]] = sat_sum(nsum_y[corners[j]], ny);
            nsum_z[corners[j]] = sat_sum(nsum_z[corners[j]], nz);
          end
        end
      end
      vna_pkg::FUNC_QUERY: begin
        nx = 0; ny = 0; nz = 0;
        res.bad = 1'b1;
        if (in_use(it.vertex_slot)) begin
          nx = nsum_x[it.vertex_slot];
          ny = nsum_y[it.vertex_slot];
          nz = nsum_z[it.vertex_slot];
          unitize(nx, ny, nz);
          res.bad = 1'b0;
        end
        res.nx = nx[vna_pkg::NORM_W-1:0];
        res.ny = ny[vna_pkg::NORM_W-1:0];
        res.nz = nz[vna_pkg::NORM_W-1:0];
        pending_normals = {pending_normals, res};
      end
      default: ;
    endcase
  endfunction

  // ---------------------------------------------------------------- drivers
  task automatic send_item(vna_pkg::item_t it);
    int gap;
    gap = quiet ? 0 : $urandom_range(0, 16);
    if (gap > 0) begin
      in_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_bus.valid       <= 1'b1;
    in_bus.func        <= it.func;
    in_bus.vertex_slot <= it.vertex_slot;
    in_bus.pos_x       <= it.pos_x;
    in_bus.pos_y       <= it.pos_y;
    in_bus.pos_z       <= it.pos_z;
    in_bus.corner_a    <= it.corner_a;
    in_bus.corner_b    <= it.corner_b;
    in_bus.corner_c    <= it.corner_c;
    do @(posedge clk_i); while (!in_bus.ready);
    apply_command(it);
    item_count++;
  endtask

  task automatic end_items();
    in_bus.valid <= 1'b0;
    @(posedge clk_i);
  endtask

  function automatic vna_pkg::item_t load_cmd(int slot, longint x, longint y, longint z);
    vna_pkg::item_t it;
    it = '0;
    it.func = vna_pkg::FUNC_LOAD;
    it.vertex_slot = slot;
    it.pos_x = x[31:0]; it.pos_y = y[31:0]; it.pos_z = z[31:0];
    return it;
  endfunction

  function automatic vna_pkg::item_t tri_cmd(int a, int b, int c);
    vna_pkg::item_t it;
    it = '0;
    it.func = vna_pkg::FUNC_TRIANGLE;
    it.corner_a = a; it.corner_b = b; it.corner_c = c;
    return it;
  endfunction

  function automatic vna_pkg::item_t query_cmd(int slot);
    vna_pkg::item_t it;
    it = '0;
    it.func = vna_pkg::FUNC_QUERY;
    it.vertex_slot = slot;
    return it;
  endfunction

  // Wait for all results, let any trailing work finish, then write the register
  task automatic set_vertex_count(int value);
    end_items();
    while (pending_normals.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    psel_i    <= 1'b1;
    penable_i <= 1'b0;
    pwrite_i  <= 1'b1;
    paddr_i   <= vna_pkg::PADDR_W'(vna_pkg::REG_VERTEX_COUNT) << 2;
    pwdata_i  <= value;
    @(posedge clk_i);
    penable_i <= 1'b1;
    do @(posedge clk_i); while (!pready_o);
    psel_i    <= 1'b0;
    penable_i <= 1'b0;
    pwrite_i  <= 1'b0;
    active_count = value;
    @(posedge clk_i);
  endtask

  // ---------------------------------------------------------------- result side
  initial begin
    int stall;
    out_bus.ready <= 1'b0;
    forever begin
      stall = quiet ? 0 : $urandom_range(0, 16);
      if (hold_request) begin
        stall = LONG_HOLD;
        hold_request = 0;
      end
      if (stall > 0) begin
        out_bus.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_bus.ready <= 1'b1;
      do @(posedge clk_i); while (!out_bus.valid);
    end
  end

  // Compare each result transfer with the oldest expected normal
  always @(posedge clk_i) begin
    normal_t exp_n;
    if (rst_ni && out_bus.valid && out_bus.ready) begin
      result_count++;
      if (pending_normals.size() == 0) begin
        $error("result transfer with no query outstanding");
        err_count++;
      end else begin
        exp_n = pending_normals.pop_front();
        if (out_bus.normal_x !== exp_n.nx) begin
          $error("normal_x expected %0d actual %0d", exp_n.nx, out_bus.normal_x);
          err_count++;
        end
        if (out_bus.normal_y !== exp_n.ny) begin
          $error("normal_y expected %0d actual %0d", exp_n.ny, out_bus.normal_y);
          err_count++;
        end
        if (out_bus.normal_z !== exp_n.nz) begin
          $error("normal_z expected %0d actual %0d", exp_n.nz, out_bus.normal_z);
          err_count++;
        end
        if (out_bus.bad_index !== exp_n.bad) begin
          $error("bad_index expected %0d actual %0d", exp_n.bad, out_bus.bad_index);
          err_count++;
        end
      end
    end
  end

  // ---------------------------------------------------------------- tests
  task automatic test_directed();
    set_vertex_count(8);
    // Extreme coordinates and a plain unit triangle
    send_item(load_cmd(0, 0, 0, 0));
    send_item(load_cmd(1, ONE_POS, 0, 0));
    send_item(load_cmd(2, 0, ONE_POS, 0));
    send_item(load_cmd(3, 64'sh7FFF_FFFF, 64'sh7FFF_FFFF, -64'sh8000_0000));
    send_item(load_cmd(4, -64'sh8000_0000, 64'sh7FFF_FFFF, 64'sh7FFF_FFFF));
    send_item(load_cmd(5, -64'sh8000_0000, -64'sh8000_0000, -64'sh8000_0000));
    send_item(load_cmd(6, -1, -1, -1));
    send_item(load_cmd(1023, 64'sh1234_5678, -64'sh0ABC_DEF0, 7));
    send_item(tri_cmd(0, 1, 2));
    send_item(tri_cmd(3, 4, 5));
    send_item(tri_cmd(5, 6, 3));
    // Degenerate: repeated corner and collinear corners
    send_item(tri_cmd(1, 1, 2));
    send_item(tri_cmd(0, 6, 5));
    // Corner out of range drops the triangle
    send_item(tri_cmd(0, 8, 2));
    send_item(tri_cmd(1023, 1, 0));
    send_item(query_cmd(0));
    send_item(query_cmd(3));
    send_item(query_cmd(5));
    send_item(query_cmd(7));
    send_item(query_cmd(8));
    send_item(query_cmd(1023));
    begin
      vna_pkg::item_t odd;
      odd = query_cmd(0);
      odd.func = vna_pkg::FUNC_NONE;
      send_item(odd);
    end
    send_item(query_cmd(1));
  endtask

  // Drive one vertex sum into both saturation limits
  task automatic test_saturation();
    quiet = 1;
    set_vertex_count(6);
    send_item(load_cmd(0, 0, 0, 0));
    send_item(load_cmd(1, ONE_POS, 0, 0));
    send_item(load_cmd(2, 0, ONE_POS, 0));
    for (int i = 0; i < 520; i++) send_item(tri_cmd(0, 1, 2));
    send_item(query_cmd(0));
    // Restart vertex zero from an empty sum so the lower limit is reached
    send_item(load_cmd(0, 0, 0, 0));
    for (int i = 0; i < 520; i++) send_item(tri_cmd(0, 2, 1));
    send_item(query_cmd(0));
    send_item(query_cmd(1));
    quiet = 0;
  endtask

  function automatic int pick_usable();
    int idx;
    for (int t = 0; t < 12; t++) begin
      idx = placed_list[$urandom_range(0, placed_list.size() - 1)];
      if (in_use(idx)) return idx;
    end
    return -1;
  endfunction

  task automatic random_phase(int count, int n_items);
    int roll, a, b, c, slot;
    vna_pkg::item_t it;
    set_vertex_count(count);
    for (int i = 0; i < n_items; i++) begin
      roll = $urandom_range(0, 99);
      if (i % 40 == 20) quiet = 1;
      if (i % 40 == 30) quiet = 0;
      if (roll < 30 || placed_list.size() < 3) begin
        slot = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 1023)
                                            : $urandom_range(0, (count > 0) ? count - 1 : 0);
        send_item(load_cmd(slot, $signed($urandom), $signed($urandom), $signed($urandom)));
      end else if (roll < 70) begin
        if (count < vna_pkg::MAX_VERTICES && $urandom_range(0, 5) == 0) begin
          it = tri_cmd($urandom_range(count, 1023), $urandom_range(0, 1023),
                       $urandom_range(0, 1023));
          if ($urandom_range(0, 1)) begin
            a = it.corner_a; it.corner_a = it.corner_c; it.corner_c = a;
          end
          send_item(it);
        end else begin
          a = pick_usable(); b = pick_usable(); c = pick_usable();
          if (a >= 0 && b >= 0 && c >= 0) send_item(tri_cmd(a, b, c));
        end
      end else if (roll < 95) begin
        slot = pick_usable();
        if (slot < 0 || $urandom_range(0, 4) == 0) slot = $urandom_range(0, 1023);
        send_item(query_cmd(slot));
      end else begin
        it = query_cmd($urandom_range(0, 1023));
        it.func = vna_pkg::FUNC_NONE;
        it.pos_x = $urandom;
        send_item(it);
      end
    end
    quiet = 0;
  endtask

  // Hold the result side off while queries pile up behind the output register
  task automatic test_backpressure();
    set_vertex_count(vna_pkg::MAX_VERTICES);
    quiet = 1;
    hold_request = 1;
    for (int i = 0; i < 12; i++) send_item(query_cmd(placed_list[i % placed_list.size()]));
    quiet = 0;
  endtask

  initial begin
    clk_i = 1'b0;
    rst_ni = 1'b0;
    psel_i <= 1'b0; penable_i <= 1'b0; pwrite_i <= 1'b0;
    paddr_i <= '0; pwdata_i <= '0;
    in_bus.valid <= 1'b0;
    in_bus.func <= '0; in_bus.vertex_slot <= '0;
    in_bus.pos_x <= '0; in_bus.pos_y <= '0; in_bus.pos_z <= '0;
    in_bus.corner_a <= '0; in_bus.corner_b <= '0; in_bus.corner_c <= '0;
    for (int i = 0; i < vna_pkg::MAX_VERTICES; i++) begin
      coord_x[i] = 0; coord_y[i] = 0; coord_z[i] = 0;
      nsum_x[i] = 0; nsum_y[i] = 0; nsum_z[i] = 0;
      placed[i] = 0;
    end
    active_count = 0;
    err_count = 0; result_count = 0; item_count = 0;
    quiet = 0; hold_request = 0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    set_vertex_count(0);
    send_item(query_cmd(0));
    send_item(query_cmd(1023));
    test_directed();
    test_saturation();
    random_phase(vna_pkg::MAX_VERTICES, 140);
    random_phase($urandom_range(2, 1023), 140);
    random_phase(16, 140);
    test_backpressure();
    random_phase(1, 20);
    set_vertex_count(0);
    send_item(query_cmd(0));

    end_items();
    while (pending_normals.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (pending_normals.size() != 0) err_count++;
    $display("Covered %0d commands (loads, triangles, queries, unused codes) and %0d results,",
             item_count, result_count);
    $display("vertex_count from 0 to %0d, sum saturation and a long output stall.",
             vna_pkg::MAX_VERTICES);
    if (err_count == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("FAILED: results differ");
    $finish;
  end

endmodule
